// File: src/abr_pkg.sv
// Shared types and helpers for the alternating-bit frame receiver.
// Holds the item structures and the ones-complement add; no dependencies.
package abr_pkg;

    localparam int unsigned WordBits = 16;

    // One received word with its frame side-band fields.
    typedef struct packed {
        logic [WordBits-1:0] frame_sum;
        logic                seq_bit;
        logic                word_last;
        logic [WordBits-1:0] data_word;
    } in_item_t;

    // One acknowledgement result.
    typedef struct packed {
        logic accepted;
        logic ack_bit;
    } result_t;

    // Handshake between the input register and the checking stage.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

    // 16-bit ones-complement add with end-around carry.
    function automatic logic [WordBits-1:0] oc_add(
        input logic [WordBits-1:0] a,
        input logic [WordBits-1:0] b
    );
        logic [WordBits:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[WordBits-1:0] + {{(WordBits-1){1'b0}}, wide[WordBits]};
    endfunction

endpackage

// File: src/abr_in_reg.sv
// Input register of the frame receiver: captures one item per cycle while the checking stage advances.
// Depends on abr_pkg for the item structure.
module abr_in_reg
    import abr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    input  logic        advance,
    output logic        valid,
    output in_item_t    item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register frees up when its item moves on in the same cycle.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded whenever a new item is taken.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: src/abr_check.sv
// Checking stage: running ones-complement sum, expected sequence bit and
// the accept decision on the last word. Depends on abr_pkg.
module abr_check
    import abr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  in_item_t    in_item,
    input  logic        out_ready,
    output stage_ctrl_t ctrl,
    output logic        res_valid,
    output result_t     res
);

    logic [WordBits-1:0] sum_reg;
    logic [WordBits-1:0] sum_next;
    logic                exp_seq_reg;
    logic                exp_seq_next;
    logic [WordBits-1:0] total;
    logic                good;
    logic                fire;

    // A word that ends a frame needs room in the result register.
    assign fire         = in_valid && (!in_item.word_last || out_ready);
    assign ctrl.valid   = in_valid;
    assign ctrl.advance = fire;

    assign total = oc_add(sum_reg, in_item.data_word);
    assign good  = (in_item.seq_bit == exp_seq_reg) && ((~total) == in_item.frame_sum);

    // Next state and the result of a completed frame.
    always_comb begin
        sum_next     = sum_reg;
        exp_seq_next = exp_seq_reg;
        res.ack_bit  = exp_seq_reg;
        res.accepted = good;
        if (good) begin
            res.ack_bit = !in_item.seq_bit;
        end
        if (fire) begin
            if (in_item.word_last) begin
                sum_next = '0;
                if (good) begin
                    exp_seq_next = !exp_seq_reg;
                end
            end else begin
                sum_next = total;
            end
        end
    end

    assign res_valid = fire && in_item.word_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            exp_seq_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            exp_seq_reg <= exp_seq_next;
        end
    end

    // The sum restarts after every frame, good or bad.
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> sum_reg == '0)
        else $error("running sum not cleared after frame end");

    // The expected bit only moves on a frame end.
    a_seq_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !res_valid |=> $stable(exp_seq_reg))
        else $error("expected sequence bit changed mid-frame");

    // An accepted frame toggles the expected bit.
    a_seq_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.accepted |=> exp_seq_reg != $past(exp_seq_reg))
        else $error("accepted frame did not toggle expected bit");

    // A rejected frame acknowledges with the expected bit.
    a_reject_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.accepted |-> res.ack_bit == exp_seq_reg)
        else $error("rejected frame acknowledged with wrong bit");

endmodule

// File: src/alternating_bit_receiver.sv
// Alternating-bit frame receiver with a ones-complement checksum check.
// A frame's last word is taken into the input register, and its result is then
// taken into the result register behind the check stage and offered on m_tvalid.
// Throughput: one word per cycle; the end-around add and compare are combinational
// between the input register and the result register. A last word waits
// in the input register while an earlier result is still held by m_tready.
// Reset (aresetn low, synchronous) clears the sum, the expected bit to zero,
// and empties both registers.
module alternating_bit_receiver
    import abr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] data_word, [31:16] frame_sum
    input  logic        s_tlast,   // word_last
    input  logic        s_tuser,   // [0] seq_bit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] ack_bit, [1] accepted, [7:2] zero
);

    in_item_t    s_item;
    in_item_t    st_item;
    logic        st_valid;
    stage_ctrl_t ctrl;
    logic        res_valid;
    result_t     res;
    logic        out_ready;
    logic        m_valid_reg;
    logic        m_valid_next;
    result_t     m_res_reg;

    assign s_item.data_word = s_tdata[15:0];
    assign s_item.frame_sum = s_tdata[31:16];
    assign s_item.word_last = s_tlast;
    assign s_item.seq_bit   = s_tuser;

    abr_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .advance (ctrl.advance),
        .valid   (st_valid),
        .item    (st_item)
    );

    abr_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st_valid),
        .in_item   (st_item),
        .out_ready (out_ready),
        .ctrl      (ctrl),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: takes a new item when empty or being drained.
    assign out_ready    = !m_valid_reg || m_tready;
    assign m_valid_next = out_ready ? res_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_res_reg.accepted, m_res_reg.ack_bit};

endmodule

// File: sim/alternating_bit_receiver_tb.sv
// Self-checking testbench for the alternating-bit frame receiver.
// Drives framed words with random idling on both sides and checks each ack item
// against its own frame model; depends on abr_pkg and alternating_bit_receiver.
`timescale 1ns / 1ps

module alternating_bit_receiver_tb;
    import abr_pkg::*;

    localparam int unsigned StimItems   = 600;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned SettleCycles = 8;

    // Idling phases of the run.
    localparam int unsigned PhaseSlowSink   = 0;
    localparam int unsigned PhaseSlowSource = 1;
    localparam int unsigned PhaseFree       = 2;

    typedef struct {
        in_item_t    word;
        bit          drain_first;
        int unsigned phase;
    } pending_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] data_word, [31:16] frame_sum
    logic        s_tlast  = 1'b0; // word_last
    logic        s_tuser  = 1'b0; // [0] seq_bit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] ack_bit, [1] accepted, [7:2] zero

    pending_t    word_queue[$];
    result_t     ack_queue[$];
    logic [15:0] frame_words[$];

    // Receiver state as predicted from the accepted items.
    logic        want_seq = 1'b0;
    logic [15:0] frame_total = '0;

    // Sequence bit the stimulus expects the receiver to be waiting for.
    logic        gen_seq = 1'b0;
    bit          hold_for_drain = 1'b0;

    int unsigned driven_count = 0;
    int unsigned taken_count  = 0;
    int unsigned cur_phase    = PhaseSlowSink;
    int unsigned cycle_count  = 0;
    int unsigned fail_count   = 0;

    alternating_bit_receiver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Ones-complement add with the carry folded back into bit 0.
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] full;
        full = {1'b0, a} + {1'b0, b};
        full = {1'b0, full[15:0]} + {16'b0, full[16]};
        return full[15:0];
    endfunction

    function automatic int unsigned source_idle_pct(input int unsigned phase);
        case (phase)
            PhaseSlowSink:   return 15;
            PhaseSlowSource: return 55;
            default:         return 0;
        endcase
    endfunction

    function automatic int unsigned sink_stall_pct(input int unsigned phase);
        case (phase)
            PhaseSlowSink:   return 55;
            PhaseSlowSource: return 15;
            default:         return 0;
        endcase
    endfunction

    // Word values weighted towards the ones that exercise the end-around carry.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000 | 16'($urandom_range(3));
            3:       return 16'hFFFF - 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // Append one item; the idling phase follows from its position in the run.
    task automatic push_word(input logic [15:0] data, input logic last, input logic seq,
                             input logic [15:0] fsum);
        pending_t    entry;
        int unsigned ph;
        if (word_queue.size() < StimItems / 3) begin
            ph = PhaseSlowSink;
        end else if (word_queue.size() < 2 * StimItems / 3) begin
            ph = PhaseSlowSource;
        end else begin
            ph = PhaseFree;
        end
        entry.word.data_word = data;
        entry.word.word_last = last;
        entry.word.seq_bit   = seq;
        entry.word.frame_sum = fsum;
        entry.phase          = ph;
        entry.drain_first    = hold_for_drain ||
                               (word_queue.size() != 0 && ph != word_queue[$].phase);
        hold_for_drain       = 1'b0;
        word_queue.push_back(entry);
    endtask

    // Turn the words in frame_words into one frame, with a good or a broken
    // checksum and an in-order or repeated sequence bit.
    task automatic push_frame(input bit sum_ok, input bit seq_ok);
        logic [15:0] total;
        logic [15:0] fsum;
        logic        seq;
        total = '0;
        foreach (frame_words[i]) total = fold_add(total, frame_words[i]);
        // Side-band fields on inner words are ignored, so they carry noise.
        for (int i = 0; i + 1 < frame_words.size(); i++) begin
            push_word(frame_words[i], 1'b0, 1'($urandom_range(1)), 16'($urandom));
        end
        fsum = ~total;
        if (!sum_ok) begin
            fsum = fsum ^ (16'd1 << $urandom_range(15));
        end
        seq = seq_ok ? gen_seq : ~gen_seq;
        push_word(frame_words[$], 1'b1, seq, fsum);
        if (sum_ok && seq_ok) begin
            gen_seq = ~gen_seq;
        end
        frame_words.delete();
    endtask

    // Work out the ack item, if any, that an accepted word causes.
    task automatic predict_ack(input logic [15:0] data, input logic last, input logic seq,
                               input logic [15:0] fsum);
        logic [15:0] total;
        result_t     res;
        total = fold_add(frame_total, data);
        if (!last) begin
            frame_total = total;
        end else begin
            res.accepted = (seq == want_seq) && (~total == fsum);
            if (res.accepted) begin
                res.ack_bit = ~seq;
                want_seq    = ~want_seq;
            end else begin
                res.ack_bit = want_seq;
            end
            frame_total = '0;
            ack_queue.push_back(res);
        end
    endtask

    // Sample both handshakes at the rising edge and check each ack item.
    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        cycle_count++;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_ack(s_tdata[15:0], s_tlast, s_tuser, s_tdata[31:16]);
                taken_count++;
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[1:0]);
                if (ack_queue.size() == 0) begin
                    $error("ack item with none expected: ack_bit %0d, accepted %0d",
                           got.ack_bit, got.accepted);
                    fail_count++;
                end else begin
                    want = ack_queue.pop_front();
                    if (got.ack_bit !== want.ack_bit) begin
                        $error("ack_bit: expected %0d, got %0d", want.ack_bit, got.ack_bit);
                        fail_count++;
                    end
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                        fail_count++;
                    end
                    if (m_tdata[7:2] !== 6'b0) begin
                        $error("padding: expected 0, got %0h", m_tdata[7:2]);
                        fail_count++;
                    end
                end
            end
        end
        if (cycle_count >= CycleLimit) begin
            $display("alternating_bit_receiver test failed");
            $finish;
        end
    end

    // Drive the next item and the result-side stall at the falling edge.
    always @(negedge aclk) begin : driver
        pending_t nxt;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct(cur_phase));
            if (driven_count == taken_count) begin
                if (word_queue.size() != 0 &&
                    (!word_queue[0].drain_first || ack_queue.size() == 0) &&
                    $urandom_range(99) >= source_idle_pct(word_queue[0].phase)) begin
                    nxt = word_queue.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {nxt.word.frame_sum, nxt.word.data_word};
                    s_tlast   <= nxt.word.word_last;
                    s_tuser   <= nxt.word.seq_bit;
                    cur_phase = nxt.phase;
                    driven_count++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned kind;
        int unsigned nwords;

        // Single zero word: the sum is zero, so the checksum is all ones.
        frame_words.push_back(16'h0000);
        push_frame(1, 1);
        // Single all-ones word with sequence bit one.
        frame_words.push_back(16'hFFFF);
        push_frame(1, 1);
        // Two all-ones words force the end-around carry.
        frame_words.push_back(16'hFFFF);
        frame_words.push_back(16'hFFFF);
        push_frame(1, 1);
        // Carry out of the top bit with a zero low half.
        frame_words.push_back(16'h8000);
        frame_words.push_back(16'h8000);
        push_frame(1, 0);
        // Correct sequence bit but a corrupted checksum.
        frame_words.push_back(16'h1234);
        frame_words.push_back(16'hABCD);
        frame_words.push_back(16'h0001);
        push_frame(0, 1);
        // Both wrong.
        frame_words.push_back(16'hFFFF);
        push_frame(0, 0);
        // A rejected frame must leave the sum cleared for the next one.
        frame_words.push_back(16'h0000);
        frame_words.push_back(16'h0000);
        push_frame(1, 1);
        hold_for_drain = 1'b1;

        // Mostly well-formed frames, with repeats and broken checksums mixed in.
        while (word_queue.size() < StimItems) begin
            kind   = $urandom_range(99);
            nwords = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
            repeat (nwords) frame_words.push_back(pick_word());
            if (word_queue.size() < StimItems / 2 && word_queue.size() + nwords >= StimItems / 2) begin
                hold_for_drain = 1'b1;
            end
            if (kind < 70) begin
                push_frame(1, 1);
            end else if (kind < 80) begin
                push_frame(1, 0);
            end else if (kind < 90) begin
                push_frame(0, 1);
            end else begin
                push_frame(0, 0);
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (word_queue.size() != 0 || driven_count != taken_count || ack_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SettleCycles) @(posedge aclk);

        if (fail_count == 0) begin
            $display("alternating_bit_receiver test passed");
        end else begin
            $display("alternating_bit_receiver test failed");
        end
        $finish;
    end

endmodule
